>>> src/lcfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared constants, codes and control types of the load cell frame
// conditioner.
// ----------------------------------------------------------------------------
package lcfc_pkg;

  // defaults for the top level parameters
  localparam int unsigned AVG_LEN_DEF  = 8;
  localparam int unsigned CHANNELS_DEF = 8;

  // frame layout
  localparam logic [4:0] STATUS_BYTES = 5'd3;
  localparam logic [4:0] FRAME_BYTES  = 5'd19;
  localparam logic [7:0] STATUS_SYNC  = 8'hC0;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_ALPHA       = 2'd1;
  localparam logic [1:0] CFG_GAIN        = 2'd2;

  // filter modes; any other code passes the sample through
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_EMA = 2'd2;

  localparam logic [15:0] ALPHA_RESET = 16'd32113;
  localparam logic [15:0] ALPHA_ONE   = 16'd32768;
  localparam logic [31:0] GAIN_RESET  = 32'd16777216;

  // reciprocal scaling for the block average divide
  localparam int unsigned RECIP_SHIFT = 26;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NONE,
    DP_PASS,
    DP_AVG,
    DP_EMA_KEEP,
    DP_EMA_NEW,
    DP_EMA_SUM,
    DP_DIV_MUL,
    DP_DIV_Q,
    DP_MAG,
    DP_SCALE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic       chk_status;   // compare byte against status pattern
    logic       status_head;  // first status byte expects the sync value
    logic       hold_hi;      // latch sample high byte
    logic       store_ofs;    // store tare for chan
    logic       calc_diff;    // sample minus tare for chan
    logic       avg_done;     // this frame closes the averaging block
    logic [2:0] chan;
    dp_op_t     op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> src/lcfc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfc_ctrl
// Frame byte tracking, block count and the sequencer that steps the datapath
// through the per-sample work.
// ----------------------------------------------------------------------------
module lcfc_ctrl import lcfc_pkg::*; #(
  parameter int unsigned AVG_LEN  = AVG_LEN_DEF,
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_first,
  input  wire logic     in_opcode,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam int unsigned CNT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_EMA1 = 9'b000000100,
    S_EMA2 = 9'b000001000,
    S_DIVM = 9'b000010000,
    S_DIVQ = 9'b000100000,
    S_MAG  = 9'b001000000,
    S_SMUL = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [2:0]       chan_r, chan_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [4:0] pos;
  logic [4:0] rel;
  logic [3:0] k4;
  logic       accept;
  logic       done;
  logic       chan_last;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign pos       = in_first ? 5'd0 : pos_r;
  assign rel       = pos - STATUS_BYTES;
  assign k4        = rel[4:1];
  assign done      = ({1'b0, cnt_r} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(AVG_LEN);
  assign chan_last = (chan_r == 3'(CHANNELS - 1));

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    chan_nxt  = chan_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = DP_NONE;
    cmd.chan  = chan_r;
    case (state_r)
      S_IDLE: begin
        cmd.chan = k4[2:0];
        if (accept) begin
          if (pos < STATUS_BYTES) begin
            cmd.chk_status  = 1'b1;
            cmd.status_head = (pos == 5'd0);
            pos_nxt         = pos + 5'd1;
          end else if (pos >= FRAME_BYTES) begin
            pos_nxt = FRAME_BYTES;
          end else begin
            pos_nxt = pos + 5'd1;
            if (!rel[0]) begin
              cmd.hold_hi = 1'b1;
            end else if (k4 < 4'(CHANNELS)) begin
              if (!in_opcode) begin
                cmd.store_ofs = 1'b1;
              end else begin
                cmd.calc_diff = 1'b1;
                chan_nxt      = k4[2:0];
                state_nxt     = S_DIFF;
              end
            end
          end
        end
      end
      S_DIFF: begin
        case (stat.mode)
          MODE_AVG: begin
            cmd.op       = DP_AVG;
            cmd.avg_done = done;
            if (chan_last) begin
              cnt_nxt = done ? '0 : cnt_r + CNT_W'(1);
            end
            state_nxt = done ? S_DIVM : S_IDLE;
          end
          MODE_EMA: begin
            cmd.op    = DP_EMA_KEEP;
            state_nxt = S_EMA1;
          end
          default: begin
            cmd.op    = DP_PASS;
            state_nxt = S_MAG;
          end
        endcase
      end
      S_EMA1: begin
        cmd.op    = DP_EMA_NEW;
        state_nxt = S_EMA2;
      end
      S_EMA2: begin
        cmd.op    = DP_EMA_SUM;
        state_nxt = S_MAG;
      end
      S_DIVM: begin
        cmd.op    = DP_DIV_MUL;
        state_nxt = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.op    = DP_DIV_Q;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op    = DP_MAG;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.op    = DP_SCALE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the product until the output register frees up
        if (stat.out_free) begin
          cmd.op    = DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= 5'd0;
      chan_r  <= 3'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      chan_r  <= chan_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/lcfc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfc_dp
// Datapath: configuration registers, tare and filter state, one shared
// multiplier, output scaling and the output register.
// ----------------------------------------------------------------------------
module lcfc_dp import lcfc_pkg::*; #(
  parameter int unsigned AVG_LEN  = AVG_LEN_DEF,
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [7:0]  in_byte,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic [31:0]      out_tdata,
  output logic [3:0]       out_tuser,
  output logic             out_tlast
);

  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RECIP    = ((2 ** RECIP_SHIFT) + AVG_LEN - 1) / AVG_LEN;

  logic [1:0]  mode_r;
  logic [15:0] alpha_r;
  logic [31:0] gain_r;
  logic        fault_r;
  logic [7:0]  hold_r;

  logic [15:0]        ofs_r  [CHANNELS];
  logic signed [19:0] sum_r  [CHANNELS];
  logic signed [31:0] filt_r [CHANNELS];

  logic signed [16:0] d_r;
  logic signed [19:0] s_r;
  logic signed [47:0] keep_r;
  logic signed [34:0] v_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic signed [65:0] prod_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [3:0]  out_user_r;
  logic        out_last_r;

  logic [CH_IDX_W-1:0] idx;
  logic [15:0]         sample;
  logic [16:0]         diff;
  logic [15:0]         alpha_c;
  logic [16:0]         alpha_om;
  logic signed [20:0]  sum_w;
  logic signed [19:0]  sum_sat;
  logic [19:0]         s_abs;
  logic [19:0]         q_mag;
  logic [19:0]         q_val;
  logic signed [49:0]  keep_rnd;
  logic signed [49:0]  ema_w;
  logic signed [31:0]  ema_f;
  logic [34:0]         v_abs;
  logic [63:0]         p_rnd;
  logic [40:0]         p_q;
  logic [31:0]         scaled;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;

  assign idx    = cmd.chan[CH_IDX_W-1:0];
  assign sample = {hold_r, in_byte};
  assign diff   = {sample[15], sample} - {ofs_r[idx][15], ofs_r[idx]};

  // alpha above one acts as one
  assign alpha_c  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_om = {1'b0, ALPHA_ONE} - {1'b0, alpha_c};

  always_comb begin
    sum_w = {sum_r[idx][19], sum_r[idx]} + {{4{d_r[16]}}, d_r};
    if (sum_w > 21'sd524287) begin
      sum_sat = 20'sh7FFFF;
    end else if (sum_w < -21'sd524288) begin
      sum_sat = 20'sh80000;
    end else begin
      sum_sat = sum_w[19:0];
    end
  end

  assign s_abs = s_r[19] ? (20'd0 - s_r) : s_r;
  assign q_mag = prod_r[RECIP_SHIFT+19:RECIP_SHIFT];
  assign q_val = s_r[19] ? (20'd0 - q_mag) : q_mag;

  // keep term rounds half up, then adds the new-sample term
  assign keep_rnd = ($signed({{2{keep_r[47]}}, keep_r}) + 50'sd16384) >>> 15;
  assign ema_w    = prod_r[49:0] + keep_rnd;

  always_comb begin
    if (ema_w > 50'sd2147483647) begin
      ema_f = 32'sh7FFFFFFF;
    end else if (ema_w < -50'sd2147483648) begin
      ema_f = 32'sh80000000;
    end else begin
      ema_f = ema_w[31:0];
    end
  end

  assign v_abs = v_r[34] ? (35'd0 - v_r) : v_r;

  // Q8.24 gain on Q17.15 value: drop 23 bits, halves away from zero
  assign p_rnd = prod_r[63:0] + (64'd1 << 22);
  assign p_q   = p_rnd[63:23];

  always_comb begin
    if (neg_r) begin
      scaled = (p_q > 41'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - p_q[31:0]);
    end else begin
      scaled = (p_q > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : p_q[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      DP_EMA_KEEP: begin
        mul_a = {16'd0, alpha_om};
        mul_b = {filt_r[idx][31], filt_r[idx]};
      end
      DP_EMA_NEW: begin
        mul_a = {17'd0, alpha_c};
        mul_b = {{16{d_r[16]}}, d_r};
      end
      DP_DIV_MUL: begin
        mul_a = {13'd0, s_abs};
        mul_b = 33'(RECIP);
      end
      DP_SCALE: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      alpha_r <= ALPHA_RESET;
      gain_r  <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER_MODE: mode_r  <= cfg_data[1:0];
        CFG_ALPHA:       alpha_r <= cfg_data[15:0];
        CFG_GAIN:        gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // state that must read as zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
      hold_r  <= 8'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        ofs_r[i]  <= '0;
        sum_r[i]  <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      if (cmd.chk_status) begin
        if (in_byte != (cmd.status_head ? STATUS_SYNC : 8'd0)) begin
          fault_r <= 1'b1;
        end
      end
      if (cmd.hold_hi) begin
        hold_r <= in_byte;
      end
      if (cmd.store_ofs) begin
        ofs_r[idx] <= sample;
      end
      if (cmd.op == DP_AVG) begin
        sum_r[idx] <= cmd.avg_done ? 20'sd0 : sum_sat;
      end
      if (cmd.op == DP_EMA_SUM) begin
        filt_r[idx] <= ema_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      d_r <= diff;
    end
    if (cmd.op == DP_AVG) begin
      s_r <= sum_sat;
    end
    if (cmd.op == DP_EMA_NEW) begin
      keep_r <= prod_r[47:0];
    end
    case (cmd.op)
      DP_PASS:    v_r <= {{3{d_r[16]}}, d_r, 15'd0};
      DP_EMA_SUM: v_r <= {{3{ema_f[31]}}, ema_f};
      DP_DIV_Q:   v_r <= {q_val, 15'd0};
      default: ;
    endcase
    if (cmd.op == DP_MAG) begin
      neg_r <= v_r[34];
      mag_r <= (v_abs[34:32] != 3'd0) ? 32'hFFFF_FFFF : v_abs[31:0];
    end
    if (cmd.op == DP_EMA_KEEP || cmd.op == DP_EMA_NEW ||
        cmd.op == DP_DIV_MUL || cmd.op == DP_SCALE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_data_r <= scaled;
      out_user_r <= {fault_r, cmd.chan};
      out_last_r <= (cmd.chan == 3'(CHANNELS - 1));
    end
  end

  assign stat.mode     = mode_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> src/load_cell_frame_conditioner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_frame_conditioner
// Converter frame parser with tare, optional block average or exponential
// filter, and gain scaling to signed Q16.16 per channel.
// ----------------------------------------------------------------------------
// Frame words are taken one a cycle whenever the block sits idle: status
// words, sample high words and tare words leave it idle. A measurement low
// word runs a short sequence through the one shared 33x33 multiplier (the
// filter or divide steps if any, then magnitude, scaling and output) and
// blocks input until its result sits in the output register; an averaged
// frame that does not close the block only adds to the sum, with no result.
// The output register lets the next word in while a result waits; a second
// result waits in the sequencer until the first is taken. cfg_ready is
// always high; write configuration only while no word is in flight.
module load_cell_frame_conditioner import lcfc_pkg::*; #(
  parameter int unsigned AVG_LEN  = AVG_LEN_DEF,
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [0] frame_first, [1] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] load_value
  output logic [3:0]       out_tuser,  // [2:0] channel, [3] fault
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lcfc_ctrl #(
    .AVG_LEN  (AVG_LEN),
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_first  (in_tuser[0]),
    .in_opcode (in_tuser[1]),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcfc_dp #(
    .AVG_LEN  (AVG_LEN),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> src/lcfc_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfc_chk
// Port-level checks of the load cell frame conditioner, bound to the top.
// ----------------------------------------------------------------------------
module lcfc_chk #(
  parameter int unsigned CHANNELS = 8
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // tlast marks the top channel only
  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[2:0] == 3'(CHANNELS - 1))))
    else $error("tlast does not match channel");

  // a new result only comes out of the busy sequence
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while input side idle");

  // idle right out of reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_tready)
    else $error("not ready after reset");

endmodule

bind load_cell_frame_conditioner lcfc_chk #(
  .CHANNELS (CHANNELS)
) u_lcfc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
